// File: sv/trcs_pkg.sv
// ----------------------------------------------------------------------------
// trcs_pkg: shared types and constants for the tile rotate / swizzle core
// Pixel and row types, rotation codes, register indexes, channel swizzle.
// ----------------------------------------------------------------------------
package trcs_pkg;

  localparam int TILE_SIZE = 4;
  localparam int PIX_W     = 32;
  localparam int ROW_IDX_W = $clog2(TILE_SIZE);
  localparam int NEED_W    = $clog2(TILE_SIZE + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 1'd1;

  localparam logic [CFG_DATA_W-1:0] CHANNEL_ORDER_RST = 32'h0001_0203;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef logic [PIX_W-1:0]                pixel_t;
  typedef logic [TILE_SIZE-1:0][PIX_W-1:0] pix_row_t;

  typedef struct packed {
    pix_row_t               pix;
    logic [ROW_IDX_W-1:0]   row;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic pop;
    logic load;
  } cell_ctrl_t;

  // Output byte i takes the source byte named by the low bits of order byte 3-i.
  function automatic pixel_t swizzle(pixel_t px, logic [CFG_DATA_W-1:0] order);
    pixel_t     res;
    logic [1:0] sel;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      sel = order[8*(3-i) +: 2];
      res[8*i +: 8] = px[8*sel +: 8];
    end
    return res;
  endfunction

endpackage

// File: sv/trcs_in_if.sv
// ----------------------------------------------------------------------------
// trcs_in_if: input row channel
// One beat carries one tile row of four pixels, left to right.
// ----------------------------------------------------------------------------
interface trcs_in_if;
  import trcs_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t in_pixel_0;
  pixel_t in_pixel_1;
  pixel_t in_pixel_2;
  pixel_t in_pixel_3;

  modport source (output valid, in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
                  input ready);
  modport sink   (input valid, in_pixel_0, in_pixel_1, in_pixel_2, in_pixel_3,
                  output ready);
endinterface

// File: sv/trcs_out_if.sv
// ----------------------------------------------------------------------------
// trcs_out_if: output row channel
// One beat carries one output row, its row index and the last flag.
// ----------------------------------------------------------------------------
interface trcs_out_if;
  import trcs_pkg::*;

  logic                 valid;
  logic                 ready;
  pixel_t               out_pixel_0;
  pixel_t               out_pixel_1;
  pixel_t               out_pixel_2;
  pixel_t               out_pixel_3;
  logic [ROW_IDX_W-1:0] out_row;
  logic                 last;

  modport source (output valid, out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3,
                  out_row, last, input ready);
  modport sink   (input valid, out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3,
                  out_row, last, output ready);
endinterface

// File: sv/trcs_row_cell.sv
// ----------------------------------------------------------------------------
// trcs_row_cell: one stage of the row capture chain
// Holds one swizzled tile row; takes the row at its input on every accepted beat.
// ----------------------------------------------------------------------------
module trcs_row_cell (
  input  logic               clk_i,
  input  logic               shift_i,
  input  trcs_pkg::pix_row_t row_i,
  output trcs_pkg::pix_row_t row_o
);
  import trcs_pkg::*;

  pix_row_t row_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

// File: sv/trcs_out_cell.sv
// ----------------------------------------------------------------------------
// trcs_out_cell: one stage of the output drain chain
// Holds one result row; loads a new result or advances from its neighbor.
// ----------------------------------------------------------------------------
module trcs_out_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trcs_pkg::cell_ctrl_t ctrl_i,
  input  logic                 nb_valid_i,
  input  trcs_pkg::result_t    nb_data_i,
  input  trcs_pkg::result_t    ld_data_i,
  output logic                 valid_o,
  output trcs_pkg::result_t    data_o
);
  import trcs_pkg::*;

  logic    valid_q;
  result_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
    end else if (ctrl_i.pop) begin
      valid_q <= nb_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= ld_data_i;
    end else if (ctrl_i.pop) begin
      data_q <= nb_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/tile_rotate_channel_swizzle_core.sv
// ----------------------------------------------------------------------------
// tile_rotate_channel_swizzle_core: 4x4 RGBA32 tile rotation with channel swizzle
//
//   port    dir  beat contents
//   in_i    in   in_pixel_0..3: one tile row, left to right
//   out_o   out  out_pixel_0..3, out_row, last: one output row
//   cfg_*   in   cfg_we_i, cfg_idx_i (0 rotation, 1 channel_order), cfg_data_i
//
// One row beat is taken per cycle in every rotation mode while the drain chain
// has room for its results. Accepted rows shift through a chain of three row
// cells; on the fourth row of a quarter-turn tile all four rotated rows load into
// the drain chain of OUT_DEPTH cells at once; results leave from cell 0 in order.
// Input ready depends only on registered occupancy, rotation and row count. Reset
// zeroes row count and occupancy, restores configuration; stored rows stay as is.
// ----------------------------------------------------------------------------
module tile_rotate_channel_swizzle_core #(
  parameter int OUT_DEPTH = 5
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  trcs_in_if.sink                              in_i,
  trcs_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [trcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [trcs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import trcs_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  rot_e                  rotation_q;
  logic [CFG_DATA_W-1:0] channel_order_q;
  logic [ROW_IDX_W-1:0]  row_count_q;
  logic [CNT_W-1:0]      count_q, count_d;

  logic                  in_acc, pop;
  pix_row_t              sw_row;
  pix_row_t              cap_row [TILE_SIZE-1];
  pix_row_t              tile    [TILE_SIZE];
  result_t               res     [TILE_SIZE];
  logic [NEED_W-1:0]     n_need;
  logic [CNT_W-1:0]      base;

  logic                  cell_valid [OUT_DEPTH];
  result_t               cell_data  [OUT_DEPTH];

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q      <= ROT_0;
      channel_order_q <= CHANNEL_ORDER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATION:      rotation_q      <= rot_e'(cfg_data_i[1:0]);
        CFG_CHANNEL_ORDER: channel_order_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw_row[0] = swizzle(in_i.in_pixel_0, channel_order_q);
  assign sw_row[1] = swizzle(in_i.in_pixel_1, channel_order_q);
  assign sw_row[2] = swizzle(in_i.in_pixel_2, channel_order_q);
  assign sw_row[3] = swizzle(in_i.in_pixel_3, channel_order_q);

  // Capture chain: cell 0 holds the previous row, the last cell the oldest.
  for (genvar k = 0; k < TILE_SIZE - 1; k++) begin : g_cap
    trcs_row_cell u_row_cell (
      .clk_i   (clk_i),
      .shift_i (in_acc),
      .row_i   ((k == 0) ? sw_row : cap_row[(k == 0) ? 0 : k - 1]),
      .row_o   (cap_row[k])
    );
  end

  // Tile rows in input order; the incoming row completes the tile.
  always_comb begin
    for (int r = 0; r < TILE_SIZE - 1; r++) begin
      tile[r] = cap_row[TILE_SIZE - 2 - r];
    end
    tile[TILE_SIZE-1] = sw_row;
  end

  always_comb begin
    for (int k = 0; k < TILE_SIZE; k++) begin
      res[k] = '0;
    end
    n_need = '0;
    case (rotation_q)
      ROT_0: begin
        n_need      = NEED_W'(1);
        res[0].pix  = sw_row;
        res[0].row  = row_count_q;
        res[0].last = 1'b1;
      end
      ROT_180: begin
        n_need = NEED_W'(1);
        for (int c = 0; c < TILE_SIZE; c++) begin
          res[0].pix[c] = sw_row[TILE_SIZE-1-c];
        end
        res[0].row  = ROW_IDX_W'(TILE_SIZE - 1) - row_count_q;
        res[0].last = 1'b1;
      end
      ROT_90, ROT_270: begin
        n_need = (row_count_q == ROW_IDX_W'(TILE_SIZE - 1)) ? NEED_W'(TILE_SIZE) : '0;
        for (int k = 0; k < TILE_SIZE; k++) begin
          for (int c = 0; c < TILE_SIZE; c++) begin
            if (rotation_q == ROT_90) begin
              res[k].pix[c] = tile[TILE_SIZE-1-c][k];
            end else begin
              res[k].pix[c] = tile[c][TILE_SIZE-1-k];
            end
          end
          res[k].row  = ROW_IDX_W'(k);
          res[k].last = (k == TILE_SIZE - 1);
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready = CNT_W'(n_need) <= (CNT_W'(OUT_DEPTH) - count_q);
  assign in_acc     = in_i.valid & in_i.ready;
  assign pop        = out_o.valid & out_o.ready;
  assign base       = count_q - CNT_W'(pop);
  assign count_d    = base + (in_acc ? CNT_W'(n_need) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        row_count_q <= row_count_q + 1'b1;
      end
    end
  end

  // Drain chain: cell 0 drives the output; new results land after the survivors.
  for (genvar i = 0; i < OUT_DEPTH; i++) begin : g_out
    logic [CNT_W-1:0] off;
    cell_ctrl_t       ctrl;
    logic             nb_valid;
    result_t          nb_data;

    assign off       = CNT_W'(i) - base;
    assign ctrl.pop  = pop;
    assign ctrl.load = in_acc && (CNT_W'(i) >= base) && (off < CNT_W'(n_need));

    if (i == OUT_DEPTH - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_data  = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[(i == OUT_DEPTH - 1) ? i : i + 1];
      assign nb_data  = cell_data[(i == OUT_DEPTH - 1) ? i : i + 1];
    end

    trcs_out_cell u_out_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .nb_valid_i (nb_valid),
      .nb_data_i  (nb_data),
      .ld_data_i  (res[off[ROW_IDX_W-1:0]]),
      .valid_o    (cell_valid[i]),
      .data_o     (cell_data[i])
    );
  end

  assign out_o.valid       = cell_valid[0];
  assign out_o.out_pixel_0 = cell_data[0].pix[0];
  assign out_o.out_pixel_1 = cell_data[0].pix[1];
  assign out_o.out_pixel_2 = cell_data[0].pix[2];
  assign out_o.out_pixel_3 = cell_data[0].pix[3];
  assign out_o.out_row     = cell_data[0].row;
  assign out_o.last        = cell_data[0].last;

  logic [OUT_DEPTH-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      valid_vec[i] = cell_valid[i];
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(OUT_DEPTH))
    else $error("drain occupancy above depth");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("drain occupancy does not match valid cells");

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> out_o.valid)
    else $error("occupied drain chain shows no valid head");

  a_tile_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && n_need == NEED_W'(TILE_SIZE)) |=> count_q >= CNT_W'(TILE_SIZE))
    else $error("rotated tile not loaded into drain chain");

  a_row_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> row_count_q == $past(row_count_q) + 1'b1)
    else $error("row count did not advance on accepted beat");

endmodule
